/* rtl/sri_pkg.sv */
// Shared types, constants and register indexes for the spike-rejecting IIR low-pass.
package sri_pkg;

  // Default datapath geometry
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  // Register field widths
  localparam int THR_W      = 16;
  localparam int LIMIT_W    = 8;
  localparam int CODE_W     = 16;
  localparam int COEF_W     = 16;
  localparam int A2_W       = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Rounding constant for the Q.16 coefficient products
  localparam int ROUND_BIT = 15;

  // Register reset values
  localparam logic [THR_W-1:0]   THR_RST   = 16'd5;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd3;
  localparam logic               CHK_RST   = 1'b1;
  localparam logic [CODE_W-1:0]  CODE_RST  = 16'hC000;
  localparam logic [COEF_W-1:0]  B1_RST    = 16'd16069;
  localparam logic [COEF_W-1:0]  B2_RST    = 16'd16069;
  localparam logic [A2_W-1:0]    A2_RST    = 17'h17D91; // -33391

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP_THRESHOLD    = 3'd0,
    CFG_JUMP_LIMIT        = 3'd1,
    CFG_CODE_CHECK_ENABLE = 3'd2,
    CFG_ERROR_CODE        = 3'd3,
    CFG_COEF_B1           = 3'd4,
    CFG_COEF_B2           = 3'd5,
    CFG_COEF_A2           = 3'd6
  } cfg_idx_t;

  // Register file contents
  typedef struct packed {
    logic [THR_W-1:0]   jump_threshold;
    logic [LIMIT_W-1:0] jump_limit;
    logic               code_check_enable;
    logic [CODE_W-1:0]  error_code;
    logic [COEF_W-1:0]  coef_b1;
    logic [COEF_W-1:0]  coef_b2;
    logic [A2_W-1:0]    coef_a2;
  } cfg_t;

  // Deglitch status handed to the filter
  typedef struct packed {
    logic first;
    logic held;
  } dg_flags_t;

endpackage

/* rtl/sri_ifs.sv */
// Channel interfaces: sample stream, result stream and configuration writes.
interface sample_if #(
  parameter int SAMPLE_BITS = sri_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface result_if #(
  parameter int SAMPLE_BITS = sri_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = sri_pkg::FRAC_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [SAMPLE_BITS+FRAC_BITS-1:0] filtered;
  logic [SAMPLE_BITS-1:0]           clean_sample;
  logic                             held;

  modport source (output valid, output filtered, output clean_sample, output held,
                  input ready);
  modport sink   (input valid, input filtered, input clean_sample, input held,
                  output ready);
endinterface

interface cfg_if;
  import sri_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sri_cfg_regs.sv */
// Configuration register file, written one word at a time.
module sri_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  cfg_if.sink          cfg,
  output sri_pkg::cfg_t regs
);
  import sri_pkg::*;

  cfg_t regs_q;

  // Always take a write
  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  // Load reset values, then update the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.jump_threshold    <= THR_RST;
      regs_q.jump_limit        <= LIMIT_RST;
      regs_q.code_check_enable <= CHK_RST;
      regs_q.error_code        <= CODE_RST;
      regs_q.coef_b1           <= B1_RST;
      regs_q.coef_b2           <= B2_RST;
      regs_q.coef_a2           <= A2_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_t'(cfg.index))
        CFG_JUMP_THRESHOLD:    regs_q.jump_threshold    <= cfg.data[THR_W-1:0];
        CFG_JUMP_LIMIT:        regs_q.jump_limit        <= cfg.data[LIMIT_W-1:0];
        CFG_CODE_CHECK_ENABLE: regs_q.code_check_enable <= cfg.data[0];
        CFG_ERROR_CODE:        regs_q.error_code        <= cfg.data[CODE_W-1:0];
        CFG_COEF_B1:           regs_q.coef_b1           <= cfg.data[COEF_W-1:0];
        CFG_COEF_B2:           regs_q.coef_b2           <= cfg.data[COEF_W-1:0];
        CFG_COEF_A2:           regs_q.coef_a2           <= cfg.data[A2_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/sri_deglitch.sv */
// Spike rejection: holds the last accepted level until enough consecutive jumps.
module sri_deglitch #(
  parameter int SAMPLE_BITS = sri_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [SAMPLE_BITS-1:0] x,
  input  sri_pkg::cfg_t          regs,
  output logic [SAMPLE_BITS-1:0] clean,
  output sri_pkg::dg_flags_t     flags
);
  import sri_pkg::*;

  localparam int CW = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic                   started;
  logic [SAMPLE_BITS-1:0] last_accepted;
  logic [LIMIT_W-1:0]     jump_count;

  logic [SAMPLE_BITS-1:0] diff;
  logic [CW-1:0]          diff_w;
  logic [CW-1:0]          thr_w;
  logic [CW-1:0]          x_w;
  logic [CW-1:0]          code_w;
  logic                   jump;
  logic [LIMIT_W:0]       count_inc;
  logic                   under_limit;
  logic                   hold;

  // Distance from the last accepted level
  assign diff   = (x >= last_accepted) ? (x - last_accepted) : (last_accepted - x);
  assign diff_w = CW'(diff);
  assign thr_w  = CW'(regs.jump_threshold);
  assign x_w    = CW'(x);
  assign code_w = CW'(regs.error_code);

  // Classify the word as a jump and decide whether to hold
  assign jump        = (diff_w >= thr_w) || (regs.code_check_enable && (x_w == code_w));
  assign count_inc   = {1'b0, jump_count} + (LIMIT_W+1)'(1);
  assign under_limit = count_inc < {1'b0, regs.jump_limit};
  assign hold        = started && jump && under_limit;

  assign clean       = hold ? last_accepted : x;
  assign flags.first = !started;
  assign flags.held  = hold;

  // Advance the deglitch state when the word moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      last_accepted <= '0;
      jump_count    <= '0;
    end else if (advance) begin
      started <= 1'b1;
      if (hold) begin
        jump_count <= count_inc[LIMIT_W-1:0];
      end else begin
        last_accepted <= x;
        jump_count    <= '0;
      end
    end
  end

endmodule

/* rtl/sri_iir.sv */
// First-order IIR section with round-to-nearest and saturation to unsigned fixed point.
module sri_iir #(
  parameter int SAMPLE_BITS = sri_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = sri_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic [SAMPLE_BITS-1:0]           clean,
  input  sri_pkg::dg_flags_t               flags,
  input  sri_pkg::cfg_t                    regs,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] filtered
);
  import sri_pkg::*;

  localparam int OW    = SAMPLE_BITS + FRAC_BITS;
  localparam int PW    = COEF_W + SAMPLE_BITS;
  localparam int FBW   = A2_W + OW + 1;
  localparam int ACC_W = A2_W + OW + 3;
  localparam int QL    = ROUND_BIT + 1;

  logic [SAMPLE_BITS-1:0]   prev_input;
  logic [OW-1:0]            prev_output;

  logic [PW-1:0]            pb1;
  logic [PW-1:0]            pb2;
  logic [PW:0]              ff_sum;
  logic signed [FBW-1:0]    a2_s;
  logic signed [FBW-1:0]    y_s;
  logic signed [FBW-1:0]    fb_prod;
  logic [ACC_W-1:0]         ff_ext;
  logic [ACC_W-1:0]         fb_ext;
  logic [ACC_W-1:0]         acc;
  logic                     neg;
  logic                     over;
  logic [OW-1:0]            y_iir;
  logic [OW-1:0]            y;

  // Feed-forward products
  assign pb1    = PW'(regs.coef_b1) * PW'(clean);
  assign pb2    = PW'(regs.coef_b2) * PW'(prev_input);
  assign ff_sum = {1'b0, pb1} + {1'b0, pb2};

  // Feedback product, signed coefficient times previous output
  assign a2_s    = $signed({{(FBW-A2_W){regs.coef_a2[A2_W-1]}}, regs.coef_a2});
  assign y_s     = $signed({{(FBW-OW){1'b0}}, prev_output});
  assign fb_prod = a2_s * y_s;

  // Accumulate: feed-forward aligned to the output fraction, minus feedback, plus half LSB
  assign ff_ext = ACC_W'(ff_sum) << FRAC_BITS;
  assign fb_ext = ACC_W'(fb_prod);
  assign acc    = ff_ext - fb_ext + (ACC_W'(1) << ROUND_BIT);

  // Clamp to the unsigned output range
  assign neg   = acc[ACC_W-1];
  assign over  = |acc[ACC_W-2:QL+OW];
  assign y_iir = neg ? '0 : (over ? '1 : acc[QL +: OW]);

  // First word passes straight through
  assign y        = flags.first ? (OW'(clean) << FRAC_BITS) : y_iir;
  assign filtered = y;

  // Advance the filter history
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_input  <= '0;
      prev_output <= '0;
    end else if (advance) begin
      prev_input  <= clean;
      prev_output <= y;
    end
  end

endmodule

/* rtl/spike_reject_iir_lowpass_top.sv */
// Top level: input register, deglitch and filter logic, result register.
// An accepted word moves from the input register through the deglitch and filter
// logic into the result register, waiting while the result register is stalled.
// Throughput: one word per cycle while the result side is not stalled.
// Reset (synchronous, active high) empties both registers, clears the filter and
// deglitch history and loads every configuration register with its default.
module spike_reject_iir_lowpass_top #(
  parameter int SAMPLE_BITS = sri_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = sri_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sample_if.sink    samples,
  result_if.source  results,
  cfg_if.sink       cfg
);
  import sri_pkg::*;

  localparam int OW = SAMPLE_BITS + FRAC_BITS;

  cfg_t                   regs;
  logic                   in_v;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   out_v;
  logic [OW-1:0]          out_filtered;
  logic [SAMPLE_BITS-1:0] out_clean;
  logic                   out_held;
  logic                   advance;
  logic [SAMPLE_BITS-1:0] clean;
  dg_flags_t              flags;
  logic [OW-1:0]          filtered;

  sri_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  sri_deglitch #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_deglitch (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .x       (in_sample),
    .regs    (regs),
    .clean   (clean),
    .flags   (flags)
  );

  sri_iir #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_iir (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .clean    (clean),
    .flags    (flags),
    .regs     (regs),
    .filtered (filtered)
  );

  // Move a word forward when the result register is free or being emptied
  assign advance       = in_v && (!out_v || results.ready);
  assign samples.ready = !in_v || advance;

  assign results.valid        = out_v;
  assign results.filtered     = out_filtered;
  assign results.clean_sample = out_clean;
  assign results.held         = out_held;

  // Valid flags of the two registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (samples.valid && samples.ready) begin
        in_v <= 1'b1;
      end else if (advance) begin
        in_v <= 1'b0;
      end
      if (advance) begin
        out_v <= 1'b1;
      end else if (results.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // Payload of the two registers
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_sample <= samples.sample;
    end
    if (advance) begin
      out_filtered <= filtered;
      out_clean    <= clean;
      out_held     <= flags.held;
    end
  end

endmodule

/* rtl/sri_checker.sv */
// Port-level checks on the top level, attached by bind.
module sri_checker #(
  parameter int SAMPLE_BITS = sri_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = sri_pkg::FRAC_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [SAMPLE_BITS+FRAC_BITS-1:0] out_filtered,
  input logic [SAMPLE_BITS-1:0]           out_clean,
  input logic                             out_held
);
  import sri_pkg::*;

  logic                   have_prev;
  logic [SAMPLE_BITS-1:0] prev_clean;

  // Track the clean sample of the last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_valid && out_ready) begin
      have_prev <= 1'b1;
    end
    if (out_valid && out_ready) begin
      prev_clean <= out_clean;
    end
  end

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(out_filtered) && $stable(out_clean) && $stable(out_held))
    else $error("stalled result changed");

  // A held word repeats the level of the word before it
  a_held_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_held |-> have_prev && (out_clean == prev_clean))
    else $error("held word does not repeat the last accepted level");

  // Input stalls only under result backpressure
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without result backpressure");

endmodule

bind spike_reject_iir_lowpass_top sri_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .FRAC_BITS   (FRAC_BITS)
) u_sri_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (samples.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_filtered (results.filtered),
  .out_clean    (results.clean_sample),
  .out_held     (results.held)
);

/* tb/spike_reject_iir_lowpass_top_tb.sv */
// Self-checking testbench for the spike-rejecting IIR low-pass: directed and random words.
module spike_reject_iir_lowpass_top_tb;
  import sri_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int OW = SB + FB;
  localparam longint OUT_MAX = (longint'(1) << OW) - 1;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [OW-1:0] filtered;
    logic [SB-1:0] clean_sample;
    logic          held;
  } lowpass_out_t;

  logic clk;
  logic rst;

  sample_if #(.SAMPLE_BITS(SB))                  samples_ch ();
  result_if #(.SAMPLE_BITS(SB), .FRAC_BITS(FB))  results_ch ();
  cfg_if                                         cfg_ch ();

  spike_reject_iir_lowpass_top #(.SAMPLE_BITS(SB), .FRAC_BITS(FB)) uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  // Mirror of the register file and of the deglitch/filter history
  cfg_t          regs_mirror;
  bit            seen_first;
  logic [SB-1:0] last_level;
  logic [7:0]    jump_run;
  logic [SB-1:0] prev_in;
  logic [OW-1:0] prev_out;

  lowpass_out_t  predicted_outputs[$];
  logic [SB-1:0] sample_backlog[$];
  int            samples_queued;
  int            samples_taken;
  int            mismatch_count;
  int            cycle_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  bit            sample_taken;

  // Deglitch one word, run it through the filter, advance the history
  function automatic lowpass_out_t deglitch_and_filter(logic [SB-1:0] x);
    lowpass_out_t  o;
    logic [SB-1:0] clean;
    logic [SB-1:0] diff;
    bit            is_jump;
    longint        acc;
    longint        q;
    o.held = 1'b0;
    if (!seen_first) begin
      seen_first = 1'b1;
      last_level = x;
      jump_run   = '0;
      prev_in    = x;
      prev_out   = OW'(x) << FB;
      o.filtered = prev_out;
      o.clean_sample = x;
      return o;
    end
    diff = (x >= last_level) ? x - last_level : last_level - x;
    is_jump = (diff >= regs_mirror.jump_threshold) ||
              (regs_mirror.code_check_enable && x == regs_mirror.error_code);
    if (is_jump && int'(jump_run) + 1 < int'(regs_mirror.jump_limit)) begin
      jump_run = jump_run + 8'd1;
      clean = last_level;
      o.held = 1'b1;
    end else begin
      jump_run = '0;
      last_level = x;
      clean = x;
    end
    // b1*x + b2*x_prev in Q.24, minus a2*y_prev, round at bit 15
    acc = (longint'(regs_mirror.coef_b1) * longint'(clean)) << FB;
    acc += (longint'(regs_mirror.coef_b2) * longint'(prev_in)) << FB;
    acc -= longint'($signed(regs_mirror.coef_a2)) * longint'(prev_out);
    acc += longint'(1) << 15;
    if (acc < 0) begin
      o.filtered = '0;
    end else begin
      q = acc >>> 16;
      if (q > OUT_MAX) o.filtered = '1;
      else o.filtered = q[OW-1:0];
    end
    o.clean_sample = clean;
    prev_in  = clean;
    prev_out = o.filtered;
    return o;
  endfunction

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sample driver: advance to the next word once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      samples_ch.valid <= 1'b0;
    end else if (!samples_ch.valid || sample_taken) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= sample_backlog.pop_front();
      end else begin
        samples_ch.valid  <= 1'b0;
        samples_ch.sample <= SB'($urandom);
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (rst) results_ch.ready <= 1'b0;
    else results_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Track register writes, predict accepted words, check results
  always @(posedge clk) begin : watch
    lowpass_out_t want;
    sample_taken = !rst && samples_ch.valid && samples_ch.ready;
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_JUMP_THRESHOLD:    regs_mirror.jump_threshold    = cfg_ch.data[THR_W-1:0];
        CFG_JUMP_LIMIT:        regs_mirror.jump_limit        = cfg_ch.data[LIMIT_W-1:0];
        CFG_CODE_CHECK_ENABLE: regs_mirror.code_check_enable = cfg_ch.data[0];
        CFG_ERROR_CODE:        regs_mirror.error_code        = cfg_ch.data[CODE_W-1:0];
        CFG_COEF_B1:           regs_mirror.coef_b1           = cfg_ch.data[COEF_W-1:0];
        CFG_COEF_B2:           regs_mirror.coef_b2           = cfg_ch.data[COEF_W-1:0];
        CFG_COEF_A2:           regs_mirror.coef_a2           = cfg_ch.data[A2_W-1:0];
        default: ;
      endcase
    end
    if (sample_taken) begin
      predicted_outputs.push_back(deglitch_and_filter(samples_ch.sample));
      samples_taken++;
    end
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (predicted_outputs.size() == 0) begin
        $error("result word with nothing predicted: filtered %0d clean_sample %0d held %0d",
               results_ch.filtered, results_ch.clean_sample, results_ch.held);
        mismatch_count++;
      end else begin
        want = predicted_outputs.pop_front();
        if (results_ch.filtered !== want.filtered) begin
          $error("filtered: expected %0d, got %0d", want.filtered, results_ch.filtered);
          mismatch_count++;
        end
        if (results_ch.clean_sample !== want.clean_sample) begin
          $error("clean_sample: expected %0d, got %0d",
                 want.clean_sample, results_ch.clean_sample);
          mismatch_count++;
        end
        if (results_ch.held !== want.held) begin
          $error("held: expected %0d, got %0d", want.held, results_ch.held);
          mismatch_count++;
        end
      end
    end
  end

  task automatic queue_sample(int v);
    sample_backlog.push_back(v[SB-1:0]);
    samples_queued++;
  endtask

  // Hold until every queued word is taken and every result has come back
  task automatic wait_drained();
    @(negedge clk);
    while (samples_taken != samples_queued || predicted_outputs.size() != 0)
      @(negedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Write all seven registers once the block is idle
  task automatic load_config(int thr, int lim, bit chk, int code, int b1, int b2,
                             logic [A2_W-1:0] a2);
    wait_drained();
    cfg_write(CFG_JUMP_THRESHOLD, CFG_DATA_W'(thr));
    cfg_write(CFG_JUMP_LIMIT, CFG_DATA_W'(lim));
    cfg_write(CFG_CODE_CHECK_ENABLE, CFG_DATA_W'(chk));
    cfg_write(CFG_ERROR_CODE, CFG_DATA_W'(code));
    cfg_write(CFG_COEF_B1, CFG_DATA_W'(b1));
    cfg_write(CFG_COEF_B2, CFG_DATA_W'(b2));
    cfg_write(CFG_COEF_A2, a2);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random words: a drifting level with spike bursts, error codes and noise
  task automatic queue_chunk(int n_words, int thr, int lim, int code);
    int level;
    int span;
    int burst;
    int spike;
    int r;
    level = $urandom_range(0, 65535);
    span = (thr > 1) ? ((thr - 1 < 300) ? thr - 1 : 300) : 4;
    while (n_words > 0) begin
      r = $urandom_range(99);
      if (r < 60) begin
        level = level + int'($urandom_range(0, 2 * span)) - span;
        if (level < 0) level = 0;
        if (level > 65535) level = 65535;
        queue_sample(level);
        n_words--;
      end else if (r < 80) begin
        burst = $urandom_range(1, (lim < 9) ? lim + 1 : 9);
        spike = $urandom_range(0, 65535);
        repeat (burst) begin
          queue_sample(spike);
          n_words--;
        end
        if (burst >= lim) level = spike;
      end else if (r < 88) begin
        queue_sample(code);
        n_words--;
      end else begin
        queue_sample($urandom_range(0, 65535));
        n_words--;
      end
    end
  endtask

  initial begin : stimulus
    int thr;
    int lim;
    bit chk;
    int code;
    int b1;
    int b2;
    logic [A2_W-1:0] a2;
    rst = 1'b1;
    samples_ch.valid  = 1'b0;
    samples_ch.sample = '0;
    results_ch.ready  = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_JUMP_THRESHOLD;
    cfg_ch.data  = '0;
    regs_mirror = '{THR_RST, LIMIT_RST, CHK_RST, CODE_RST, B1_RST, B2_RST, A2_RST};
    seen_first = 1'b0;
    last_level = '0;
    jump_run   = '0;
    prev_in    = '0;
    prev_out   = '0;
    send_idle_pct = 28;
    recv_idle_pct = 68;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: first word passes through, small steps, held spikes,
    // spike accepted on the third repeat, error code held, full-scale swings
    queue_sample(100);
    queue_sample(102);
    queue_sample(200);
    queue_sample(200);
    queue_sample(200);
    queue_sample(49150);
    queue_sample(49150);
    queue_sample(49150);
    queue_sample(49152);
    queue_sample(49151);
    queue_sample(65535);
    queue_sample(0);

    // Zero threshold and zero limit: every word a jump, taken at once;
    // largest gains drive the output into the top rail
    load_config(0, 0, 1'b0, 0, 65535, 65535, 17'h10000);
    queue_sample(65535);
    queue_sample(65535);
    queue_sample(0);
    queue_sample(32768);

    // Positive feedback coefficient with no input gain: result goes negative, clamp at zero
    load_config(0, 0, 1'b0, 0, 0, 0, 17'h0FFFF);
    queue_sample(65535);
    queue_sample(1);

    // Build a long jump run, then lower the limit below it
    load_config(10, 1, 1'b1, 0, int'(B1_RST), int'(B2_RST), A2_RST);
    queue_sample(1000);
    load_config(10, 255, 1'b1, 0, int'(B1_RST), int'(B2_RST), A2_RST);
    queue_sample(1003);
    queue_sample(0);
    queue_sample(5000);
    queue_sample(5000);
    load_config(10, 2, 1'b1, 0, int'(B1_RST), int'(B2_RST), A2_RST);
    queue_sample(5000);

    // Random chunks, each with its own register settings
    for (int chunk = 0; chunk < 8; chunk++) begin
      case ($urandom_range(5))
        0: thr = 0;
        1: thr = 65535;
        2, 3: thr = $urandom_range(1, 64);
        4: thr = $urandom_range(65, 4000);
        default: thr = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(4))
        0: lim = 1;
        1: lim = 255;
        2: lim = 3;
        default: lim = $urandom_range(1, 8);
      endcase
      chk  = 1'($urandom_range(1));
      code = $urandom_range(0, 65535);
      if ($urandom_range(1) == 0) begin
        b1 = int'(B1_RST);
        b2 = int'(B2_RST);
        a2 = A2_RST;
      end else begin
        b1 = $urandom_range(0, 65535);
        b2 = $urandom_range(0, 65535);
        a2 = A2_W'($urandom_range(0, 131071));
      end
      if (chunk == 1) begin
        lim = 255;
        chk = 1'b0;
        b1 = 65535;
        b2 = 65535;
        a2 = 17'h10000;
      end else if (chunk == 6) begin
        thr = 65535;
        lim = 1;
        chk = 1'b1;
        code = 65535;
        b1 = 0;
        b2 = 0;
        a2 = 17'h0FFFF;
      end
      load_config(thr, lim, chk, code, b1, b2, a2);
      if (chunk < 3) begin
        send_idle_pct = 28;
        recv_idle_pct = 68;
      end else if (chunk < 6) begin
        send_idle_pct = 68;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_chunk(125, thr, lim, code);
    end

    // Drain, let the pipeline settle, report
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && predicted_outputs.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
rtl/sri_pkg.sv
rtl/sri_ifs.sv
rtl/sri_cfg_regs.sv
rtl/sri_deglitch.sv
rtl/sri_iir.sv
rtl/spike_reject_iir_lowpass_top.sv
rtl/sri_checker.sv
tb/spike_reject_iir_lowpass_top_tb.sv
